[sv/su8v_pkg.sv]
// shared constants and types for the strict utf-8 checker
package su8v_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

  typedef logic [OFFSET_WIDTH-1:0] offset_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERLONG  = 3'd1,
    ERR_SURROGATE = 3'd2,
    ERR_ABOVE_MAX = 3'd3,
    ERR_BAD_LEAD  = 3'd4,
    ERR_BAD_CONT  = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_code_t;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_END  = 1'b1
  } func_t;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] OVL2_LO    = 8'hC0;
  localparam logic [7:0] OVL2_HI    = 8'hC1;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD3_LO   = 8'hE1;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] LEAD4_LO   = 8'hF1;
  localparam logic [7:0] LEAD4_HI   = 8'hF3;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_E0_LO = 8'hA0;
  localparam logic [7:0] CONT_ED_HI = 8'h9F;
  localparam logic [7:0] CONT_F0_LO = 8'h90;
  localparam logic [7:0] CONT_F4_HI = 8'h8F;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

endpackage

[sv/su8v_if.sv]
// handshake channels of the strict utf-8 checker
interface su8v_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_value;
  modport source (output valid, output func, output byte_value, input ready);
  modport sink (input valid, input func, input byte_value, output ready);
endinterface

interface su8v_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  error_code;
  logic [31:0] error_offset;
  logic        string_done;
  modport source (output valid, output error_code, output error_offset,
                  output string_done, input ready);
  modport sink (input valid, input error_code, input error_offset,
                input string_done, output ready);
endinterface

interface su8v_cfg_if;
  logic valid;
  logic ready;
  logic check_enable;
  modport source (output valid, output check_enable, input ready);
  modport sink (input valid, input check_enable, output ready);
endinterface

[sv/strict_utf8_validator_core.sv]
// strict utf-8 checker: one byte per beat, sticky first error, verdict on end beat
//
// in_ch carries one content byte (func = 0) or an end-of-string marker
// (func = 1) per beat. every input beat yields exactly one result beat on
// out_ch: the first error of the string so far and the offset of the
// offending byte, with string_done set on the result of the end beat, after
// which all string state is cleared for the next string.
// cfg_ch writes check_enable; with it low every result reports no error
// while the byte offset still counts. write it only while the block is idle.
// the result is registered (result register, or skid register while out_ch
// stalls). throughput: one beat per cycle while in_ch.ready is high, set by
// the combinational update of the sequence state from registered state and byte.
// a two-entry output stage (result register plus skid register) keeps
// in_ch.ready high while one finished result waits; in_ch.ready is low
// exactly while the skid register holds a beat, from the edge where a stalled
// out_ch leaves both entries full until out_ch takes a beat.
// reset (rst_n low, synchronous) clears the string state, disables checking
// and empties the output stage.
module strict_utf8_validator_core (
  input  logic          clk,
  input  logic          rst_n,
  su8v_in_if.sink       in_ch,
  su8v_out_if.source    out_ch,
  su8v_cfg_if.sink      cfg_ch
);
  import su8v_pkg::*;

  logic      check_en_r;
  logic [1:0] pending_r,    pending_nxt;
  logic [7:0] first_low_r,  first_low_nxt;
  logic [7:0] first_high_r, first_high_nxt;
  logic      first_open_r, first_open_nxt;
  err_code_t lead_fault_r, lead_fault_nxt;
  offset_t   lead_off_r,   lead_off_nxt;
  offset_t   byte_off_r,   byte_off_nxt;
  err_code_t sticky_r,     sticky_nxt;
  offset_t   sticky_off_r, sticky_off_nxt;

  err_code_t res_code;
  offset_t   res_off;
  logic      res_done;

  // output stage
  logic        out_valid_r;
  err_code_t   out_code_r;
  logic [31:0] out_off_r;
  logic        out_done_r;
  logic        skid_valid_r;
  err_code_t   skid_code_r;
  logic [31:0] skid_off_r;
  logic        skid_done_r;

  logic        in_fire;
  logic        out_fire;
  logic [63:0] res_off_wide;
  logic [31:0] res_off_32;

  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;

  assign res_off_wide = 64'(res_off);
  assign res_off_32   = res_off_wide[31:0];

  always_comb begin
    pending_nxt    = pending_r;
    first_low_nxt  = first_low_r;
    first_high_nxt = first_high_r;
    first_open_nxt = first_open_r;
    lead_fault_nxt = lead_fault_r;
    lead_off_nxt   = lead_off_r;
    byte_off_nxt   = byte_off_r;
    sticky_nxt     = sticky_r;
    sticky_off_nxt = sticky_off_r;
    res_code       = ERR_NONE;
    res_off        = '0;
    res_done       = 1'b0;

    if (in_fire) begin
      if (in_ch.func == FUNC_BYTE) begin
        if (byte_off_r != OFF_MAX) begin
          byte_off_nxt = byte_off_r + 1'b1;
        end
        if (check_en_r && sticky_r == ERR_NONE) begin
          if (pending_r == 2'd0) begin
            case (in_ch.byte_value) inside
              [8'h00:ASCII_MAX]: begin
              end
              [LEAD2_LO:LEAD2_HI]: begin
                pending_nxt    = 2'd1;
                first_low_nxt  = CONT_LO;
                first_high_nxt = CONT_HI;
                lead_fault_nxt = ERR_NONE;
              end
              LEAD_E0: begin
                pending_nxt    = 2'd2;
                first_low_nxt  = CONT_E0_LO;
                first_high_nxt = CONT_HI;
                lead_fault_nxt = ERR_OVERLONG;
              end
              LEAD_ED: begin
                pending_nxt    = 2'd2;
                first_low_nxt  = CONT_LO;
                first_high_nxt = CONT_ED_HI;
                lead_fault_nxt = ERR_SURROGATE;
              end
              [LEAD3_LO:LEAD3_HI]: begin
                pending_nxt    = 2'd2;
                first_low_nxt  = CONT_LO;
                first_high_nxt = CONT_HI;
                lead_fault_nxt = ERR_NONE;
              end
              LEAD_F0: begin
                pending_nxt    = 2'd3;
                first_low_nxt  = CONT_F0_LO;
                first_high_nxt = CONT_HI;
                lead_fault_nxt = ERR_OVERLONG;
              end
              LEAD_F4: begin
                pending_nxt    = 2'd3;
                first_low_nxt  = CONT_LO;
                first_high_nxt = CONT_F4_HI;
                lead_fault_nxt = ERR_ABOVE_MAX;
              end
              [LEAD4_LO:LEAD4_HI]: begin
                pending_nxt    = 2'd3;
                first_low_nxt  = CONT_LO;
                first_high_nxt = CONT_HI;
                lead_fault_nxt = ERR_NONE;
              end
              [OVL2_LO:OVL2_HI]: begin
                sticky_nxt     = ERR_OVERLONG;
                sticky_off_nxt = byte_off_r;
              end
              default: begin
                sticky_nxt     = ERR_BAD_LEAD;
                sticky_off_nxt = byte_off_r;
              end
            endcase
            // any lead that opened a sequence records where it sits
            if (pending_nxt != 2'd0) begin
              first_open_nxt = 1'b1;
              lead_off_nxt   = byte_off_r;
            end
          end else if (in_ch.byte_value >= CTRL_LIMIT) begin
            // control bytes inside a sequence fall through untouched
            if (in_ch.byte_value < CONT_LO || in_ch.byte_value > CONT_HI) begin
              sticky_nxt     = ERR_BAD_CONT;
              sticky_off_nxt = byte_off_r;
            end else if (first_open_r && (in_ch.byte_value < first_low_r ||
                                          in_ch.byte_value > first_high_r)) begin
              first_open_nxt = 1'b0;
              sticky_nxt     = lead_fault_r;
              sticky_off_nxt = lead_off_r;
            end else begin
              first_open_nxt = 1'b0;
              pending_nxt    = pending_r - 2'd1;
            end
          end
        end
        res_code = check_en_r ? sticky_nxt : ERR_NONE;
        res_off  = check_en_r ? sticky_off_nxt : '0;
      end else begin
        if (check_en_r && pending_r != 2'd0 && sticky_r == ERR_NONE) begin
          sticky_nxt     = ERR_TRUNCATED;
          sticky_off_nxt = lead_off_r;
        end
        res_code       = check_en_r ? sticky_nxt : ERR_NONE;
        res_off        = check_en_r ? sticky_off_nxt : '0;
        res_done       = 1'b1;
        pending_nxt    = 2'd0;
        first_low_nxt  = '0;
        first_high_nxt = '0;
        first_open_nxt = 1'b0;
        lead_fault_nxt = ERR_NONE;
        lead_off_nxt   = '0;
        byte_off_nxt   = '0;
        sticky_nxt     = ERR_NONE;
        sticky_off_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r   <= 1'b0;
      pending_r    <= 2'd0;
      first_low_r  <= '0;
      first_high_r <= '0;
      first_open_r <= 1'b0;
      lead_fault_r <= ERR_NONE;
      lead_off_r   <= '0;
      byte_off_r   <= '0;
      sticky_r     <= ERR_NONE;
      sticky_off_r <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        check_en_r <= cfg_ch.check_enable;
      end
      pending_r    <= pending_nxt;
      first_low_r  <= first_low_nxt;
      first_high_r <= first_high_nxt;
      first_open_r <= first_open_nxt;
      lead_fault_r <= lead_fault_nxt;
      lead_off_r   <= lead_off_nxt;
      byte_off_r   <= byte_off_nxt;
      sticky_r     <= sticky_nxt;
      sticky_off_r <= sticky_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_code_r   <= skid_code_r;
        out_off_r    <= skid_off_r;
        out_done_r   <= skid_done_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        // result register still held, park the new beat
        skid_code_r  <= res_code;
        skid_off_r   <= res_off_32;
        skid_done_r  <= res_done;
        skid_valid_r <= 1'b1;
      end else begin
        out_code_r  <= res_code;
        out_off_r   <= res_off_32;
        out_done_r  <= res_done;
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.error_code   = out_code_r;
  assign out_ch.error_offset = out_off_r;
  assign out_ch.string_done  = out_done_r;

endmodule

[test/strict_utf8_validator_core_tb.sv]
// self-checking testbench for strict_utf8_validator_core: utf-8 strings, random stalls, verdict check
`timescale 1ns / 100ps

module strict_utf8_validator_core_tb;
  import su8v_pkg::*;

  typedef struct {
    err_code_t   code;
    logic [31:0] off;
    logic        done;
  } verdict_t;

  class verdict_predictor;
    bit         en;
    logic [1:0] pend;
    logic [7:0] lo;
    logic [7:0] hi;
    bit         slot_open;
    err_code_t  lead_fault;
    offset_t    lead_off;
    offset_t    next_off;
    err_code_t  sticky;
    offset_t    sticky_off;
    verdict_t   verdicts_due[$];
    int         fails;

    function new();
      en = 1'b0;
      fails = 0;
      wipe();
    endfunction

    function void wipe();
      pend = '0;
      lo = '0;
      hi = '0;
      slot_open = 1'b0;
      lead_fault = ERR_NONE;
      lead_off = '0;
      next_off = '0;
      sticky = ERR_NONE;
      sticky_off = '0;
    endfunction

    function void set_check(bit value);
      en = value;
    endfunction

    function int waiting();
      return verdicts_due.size();
    endfunction

    function void flag(err_code_t code, offset_t off);
      if (sticky == ERR_NONE) begin
        sticky = code;
        sticky_off = off;
      end
    endfunction

    function void open_seq(logic [1:0] count, logic [7:0] low, logic [7:0] high,
                           err_code_t fault);
      pend = count;
      lo = low;
      hi = high;
      slot_open = 1'b1;
      lead_fault = fault;
      lead_off = next_off;
    endfunction

    function void scan_byte(logic [7:0] b);
      if (sticky != ERR_NONE) return;
      if (pend == 2'd0) begin
        if (b <= ASCII_MAX) return;
        if (b >= LEAD2_LO && b <= LEAD2_HI) open_seq(2'd1, CONT_LO, CONT_HI, ERR_NONE);
        else if (b == LEAD_E0) open_seq(2'd2, CONT_E0_LO, CONT_HI, ERR_OVERLONG);
        else if (b == LEAD_ED) open_seq(2'd2, CONT_LO, CONT_ED_HI, ERR_SURROGATE);
        else if (b >= LEAD3_LO && b <= LEAD3_HI) open_seq(2'd2, CONT_LO, CONT_HI, ERR_NONE);
        else if (b == LEAD_F0) open_seq(2'd3, CONT_F0_LO, CONT_HI, ERR_OVERLONG);
        else if (b == LEAD_F4) open_seq(2'd3, CONT_LO, CONT_F4_HI, ERR_ABOVE_MAX);
        else if (b >= LEAD4_LO && b <= LEAD4_HI) open_seq(2'd3, CONT_LO, CONT_HI, ERR_NONE);
        else if (b == OVL2_LO || b == OVL2_HI) flag(ERR_OVERLONG, next_off);
        else flag(ERR_BAD_LEAD, next_off);
        return;
      end
      // control bytes inside a sequence are skipped
      if (b < CTRL_LIMIT) return;
      if (b < CONT_LO || b > CONT_HI) begin
        flag(ERR_BAD_CONT, next_off);
        return;
      end
      if (slot_open) begin
        slot_open = 1'b0;
        if (b < lo || b > hi) begin
          flag(lead_fault, lead_off);
          return;
        end
      end
      pend = pend - 2'd1;
    endfunction

    function void note_beat(func_t f, logic [7:0] b);
      verdict_t v;
      if (f == FUNC_BYTE) begin
        if (en) scan_byte(b);
        if (next_off != OFF_MAX) next_off = next_off + 1'b1;
        v.done = 1'b0;
      end else begin
        if (en && pend != 2'd0) flag(ERR_TRUNCATED, lead_off);
        v.done = 1'b1;
      end
      v.code = en ? sticky : ERR_NONE;
      v.off = en ? sticky_off[31:0] : '0;
      if (f == FUNC_END) wipe();
      verdicts_due.push_back(v);
    endfunction

    function void check_result(logic [2:0] code, logic [31:0] off, logic done);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("result beat with no verdict pending: code %0d offset %0d", code, off);
        fails++;
        return;
      end
      v = verdicts_due.pop_front();
      if (code !== v.code) begin
        $error("error_code: expected %0d, actual %0d", v.code, code);
        fails++;
      end
      if (off !== v.off) begin
        $error("error_offset: expected %0d, actual %0d", v.off, off);
        fails++;
      end
      if (done !== v.done) begin
        $error("string_done: expected %0d, actual %0d", v.done, done);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  su8v_in_if  in_ch();
  su8v_out_if out_ch();
  su8v_cfg_if cfg_ch();

  strict_utf8_validator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  verdict_predictor board;
  logic [7:0] text_q[$];
  int sent;
  bit idle_on;
  bit long_hold;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: check every beat, random stall bursts, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result(out_ch.error_code, out_ch.error_offset, out_ch.string_done);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 300;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick(logic [7:0] low, logic [7:0] high);
    return 8'($urandom_range(int'(high), int'(low)));
  endfunction

  task automatic send_beat(func_t f, logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    board.note_beat(f, b);
    sent++;
  endtask

  task automatic send_text(bit with_end);
    foreach (text_q[i]) send_beat(FUNC_BYTE, text_q[i]);
    if (with_end) send_beat(FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  // stop offering and wait until every verdict is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_check(bit en);
    cfg_ch.valid <= 1'b1;
    cfg_ch.check_enable <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.set_check(en);
  endtask

  // one well-formed code point
  task automatic add_char();
    logic [7:0] lead;
    logic [7:0] low;
    logic [7:0] high;
    int n;
    n = 0;
    low = CONT_LO;
    high = CONT_HI;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: lead = pick(8'h00, ASCII_MAX);
      4, 5: begin
        lead = pick(LEAD2_LO, LEAD2_HI);
        n = 1;
      end
      6, 7: begin
        lead = pick(LEAD_E0, LEAD3_HI);
        n = 2;
        if (lead == LEAD_E0) low = CONT_E0_LO;
        if (lead == LEAD_ED) high = CONT_ED_HI;
      end
      default: begin
        lead = pick(LEAD_F0, LEAD_F4);
        n = 3;
        if (lead == LEAD_F0) low = CONT_F0_LO;
        if (lead == LEAD_F4) high = CONT_F4_HI;
      end
    endcase
    text_q.push_back(lead);
    for (int i = 0; i < n; i++)
      text_q.push_back(i == 0 ? pick(low, high) : pick(CONT_LO, CONT_HI));
  endtask

  // mostly valid text, sometimes damaged by one edit, sometimes pure noise
  task automatic build_text();
    int pos;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 8)) add_char();
    if (text_q.size() == 0) return;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 9))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: text_q.delete(pos);
      2: text_q.insert(pos, 8'($urandom_range(0, int'(CTRL_LIMIT) - 1)));
      3: text_q.insert(pos, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int quota;
    board = new();
    sent = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_BYTE;
    in_ch.byte_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.check_enable = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // checking is off after reset
    text_q = '{8'h00, 8'hFF};
    send_text(1'b1);
    settle();
    write_check(1'b1);

    text_q = '{8'hC0};
    send_text(1'b1);
    // control byte skipped, then a surrogate
    text_q = '{8'hED, 8'h0A, 8'hA0};
    send_text(1'b1);
    text_q = '{8'hF4, 8'h90};
    send_text(1'b1);
    text_q = '{8'h80};
    send_text(1'b1);
    text_q = '{8'hC2, 8'h41};
    send_text(1'b1);
    text_q = '{8'hE0, 8'h9F};
    send_text(1'b1);
    text_q = '{8'hF1, 8'h1F, 8'h80, 8'hBF};
    send_text(1'b1);

    phase = 0;
    while (sent < 1100) begin
      settle();
      write_check(phase % 3 != 1);
      idle_on = (sent < 950) && (phase % 4 != 3);
      if (phase == 2) long_hold = 1'b1;
      quota = sent + $urandom_range(60, 160);
      while (sent < quota && sent < 1100) begin
        if (sent >= 950) idle_on = 1'b0;
        build_text();
        // a string left open runs on into the next one, across phases too
        send_text($urandom_range(0, 9) != 0);
      end
      phase++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (board.fails == 0 && board.waiting() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
